### rtl/affine_transform_stack_defines.svh
// Assertion macros shared by the affine transform stack RTL.
`ifndef AFFINE_TRANSFORM_STACK_DEFINES_SVH
`define AFFINE_TRANSFORM_STACK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define AT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("affine_transform_stack: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("affine_transform_stack: next-cycle check failed");

`else

`define AT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/atstk_pkg.sv
// Package with the types, constants and helpers of the affine transform stack.
`timescale 1ns / 1ps

package atstk_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int COEF_WIDTH  = 32;
	localparam int NUM_TERMS   = 6;

	localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int TERM_W    = 3;
	localparam int ADDR_W    = SLOT_W + TERM_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;

	typedef logic [COEF_WIDTH-1:0] coef_t;

	localparam coef_t COEF_ONE = COEF_WIDTH'(1);

	// Operation codes.
	localparam logic [2:0] OP_COMPOSE   = 3'd0;
	localparam logic [2:0] OP_TRANSLATE = 3'd1;
	localparam logic [2:0] OP_SAVE      = 3'd2;
	localparam logic [2:0] OP_RESTORE   = 3'd3;
	localparam logic [2:0] OP_POINT     = 3'd4;
	localparam logic [2:0] OP_VECTOR    = 3'd5;
	localparam logic [2:0] OP_DIRECTION = 3'd6;

	// Status codes.
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_BOTTOM = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;
	localparam logic [1:0] STATUS_BADDIR = 2'd3;

	// Term indexes of a transform.
	localparam logic [TERM_W-1:0] T_XX = 3'd0;
	localparam logic [TERM_W-1:0] T_XY = 3'd1;
	localparam logic [TERM_W-1:0] T_YX = 3'd2;
	localparam logic [TERM_W-1:0] T_YY = 3'd3;
	localparam logic [TERM_W-1:0] T_WX = 3'd4;
	localparam logic [TERM_W-1:0] T_WY = 3'd5;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] m_xx;
		logic signed [31:0] m_xy;
		logic signed [31:0] m_yx;
		logic signed [31:0] m_yy;
		logic signed [31:0] m_wx;
		logic signed [31:0] m_wy;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [7:0]         direction;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic en;
		logic first;
	} mac_ctrl_t;

	// Sign-extend or truncate a 32-bit field to the coefficient width.
	function automatic coef_t to_coef(logic signed [31:0] v);
		return COEF_WIDTH'(v);
	endfunction

	// Low 32 bits of a coefficient, zero-extended when coefficients are narrower.
	function automatic logic signed [31:0] to_out(coef_t c);
		return 32'(c);
	endfunction

endpackage

### rtl/atstk_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module atstk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/atstk_mac.sv
// Shared multiply-accumulate unit that works out every product of the block.
`timescale 1ns / 1ps

module atstk_mac (
	input  logic                clk,
	input  atstk_pkg::mac_ctrl_t ctrl,
	input  atstk_pkg::coef_t    a,
	input  atstk_pkg::coef_t    b,
	output atstk_pkg::coef_t    acc
);

	atstk_pkg::coef_t prod;
	atstk_pkg::coef_t base;
	atstk_pkg::coef_t acc_q;

	// Products wrap at the coefficient width, so only the low half is kept.
	assign prod = a * b;
	assign base = ctrl.first ? '0 : acc_q;
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= base + prod;
		end
	end

endmodule

### rtl/affine_transform_stack.sv
// Top level: 2D affine transform with save stack around a shared multiply-accumulate unit.
//
//   channel   handshake                   payload
//   input     item_valid / item_ready     item   (atstk_pkg::item_t)
//   output    result_valid / result_ready result (atstk_pkg::result_t)
//
// One item at a time; the work each operation does before the next item is accepted:
// compose and translate fourteen MAC steps, apply point six steps, apply vector
// and direction four steps, save and restore six RAM accesses; rejected and unused
// operations do none. The single MAC unit sets the step counts.
// Reset leaves the identity transform and an empty stack; stack memory needs no clearing.
// A result that waits on result_ready holds the next item in its final cycle.
`timescale 1ns / 1ps
`include "affine_transform_stack_defines.svh"

module affine_transform_stack (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  atstk_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output atstk_pkg::result_t result
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC    = 3'd1;
	localparam logic [2:0] ST_SAVE   = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_W = 2'd2;

	localparam logic [7:0] CH_N_UP = 8'h4E;
	localparam logic [7:0] CH_N_LO = 8'h6E;
	localparam logic [7:0] CH_E_UP = 8'h45;
	localparam logic [7:0] CH_E_LO = 8'h65;
	localparam logic [7:0] CH_S_UP = 8'h53;
	localparam logic [7:0] CH_S_LO = 8'h73;
	localparam logic [7:0] CH_W_UP = 8'h57;
	localparam logic [7:0] CH_W_LO = 8'h77;

	localparam logic [atstk_pkg::CNT_W-1:0] CNT_FULL =
		atstk_pkg::CNT_W'(atstk_pkg::STACK_DEPTH);

	logic [2:0]                      state_q;
	logic [2:0]                      op_q;
	logic [1:0]                      status_q;
	logic [atstk_pkg::CNT_W-1:0]     count_q;
	logic [atstk_pkg::TERM_W-1:0]    term_q;
	logic [1:0]                      phase_q;
	logic                            wr_s1;
	logic                            from_mem_s1;
	logic [atstk_pkg::TERM_W-1:0]    term_s1;
	logic                            res_valid_q;
	atstk_pkg::result_t              res_q;

	atstk_pkg::coef_t cur_q [atstk_pkg::NUM_TERMS];
	atstk_pkg::coef_t new_q [atstk_pkg::NUM_TERMS];
	atstk_pkg::coef_t b_q   [atstk_pkg::NUM_TERMS];

	logic                          col;
	logic [1:0]                    row;
	logic                          is_comp;
	logic                          is_apply;
	logic                          need_w;
	logic                          last_phase;
	logic                          last_term;
	logic [atstk_pkg::TERM_W-1:0]  a_idx;
	logic [atstk_pkg::TERM_W-1:0]  b_idx;
	atstk_pkg::coef_t              a_val;
	atstk_pkg::coef_t              b_val;
	atstk_pkg::coef_t              acc;
	atstk_pkg::mac_ctrl_t          mac_ctrl;
	logic                          finish_go;

	logic                          dir_ok;
	atstk_pkg::coef_t              dir_x;
	atstk_pkg::coef_t              dir_y;

	logic                          ram_we;
	logic [atstk_pkg::ADDR_W-1:0]  ram_addr;
	logic [atstk_pkg::SLOT_W-1:0]  save_slot;
	logic [atstk_pkg::SLOT_W-1:0]  load_slot;
	atstk_pkg::coef_t              ram_rdata;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Direction letters map to unit vectors; anything else is flagged.
	always_comb begin
		dir_ok = 1'b1;
		dir_x  = '0;
		dir_y  = '0;
		if (item.direction inside {CH_N_UP, CH_N_LO}) begin
			dir_y = atstk_pkg::COEF_ONE;
		end else if (item.direction inside {CH_E_UP, CH_E_LO}) begin
			dir_x = atstk_pkg::COEF_ONE;
		end else if (item.direction inside {CH_S_UP, CH_S_LO}) begin
			dir_y = '1;
		end else if (item.direction inside {CH_W_UP, CH_W_LO}) begin
			dir_x = '1;
		end else begin
			dir_ok = 1'b0;
		end
	end

	// Each result term is a sum of two products, plus the translation term
	// (multiplied by one) for the translation row and for point mapping.
	always_comb begin
		col        = term_q[0];
		row        = term_q[2:1];
		is_comp    = (op_q == atstk_pkg::OP_COMPOSE) || (op_q == atstk_pkg::OP_TRANSLATE);
		is_apply   = (op_q == atstk_pkg::OP_POINT) || (op_q == atstk_pkg::OP_VECTOR) ||
		             (op_q == atstk_pkg::OP_DIRECTION);
		need_w     = (op_q == atstk_pkg::OP_POINT) || (is_comp && (row == 2'd2));
		last_phase = need_w ? (phase_q == PH_W) : (phase_q == PH_B);
		last_term  = is_comp ? (term_q == atstk_pkg::T_WY) : (term_q == atstk_pkg::T_XY);

		if (state_q == ST_SAVE) begin
			a_idx = term_q;
		end else if (phase_q == PH_W) begin
			a_idx = {2'b10, col};
		end else begin
			a_idx = {1'b0, phase_q[0], col};
		end
		b_idx = {row, phase_q[0]};

		a_val = cur_q[a_idx];
		b_val = (phase_q == PH_W) ? atstk_pkg::COEF_ONE : b_q[b_idx];

		mac_ctrl.en    = (state_q == ST_MAC);
		mac_ctrl.first = (phase_q == PH_A);

		finish_go = (state_q == ST_FINISH) && !wr_s1 && (!res_valid_q || result_ready);
	end

	assign save_slot = count_q[atstk_pkg::SLOT_W-1:0];
	assign load_slot = atstk_pkg::SLOT_W'(count_q - atstk_pkg::CNT_W'(1));
	assign ram_we    = (state_q == ST_SAVE);
	assign ram_addr  = {(state_q == ST_SAVE) ? save_slot : load_slot, term_q};

	atstk_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.a    (a_val),
		.b    (b_val),
		.acc  (acc)
	);

	atstk_ram #(
		.WIDTH (atstk_pkg::COEF_WIDTH),
		.DEPTH (atstk_pkg::RAM_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (a_val),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= atstk_pkg::OP_COMPOSE;
			status_q    <= atstk_pkg::STATUS_OK;
			count_q     <= '0;
			term_q      <= atstk_pkg::T_XX;
			phase_q     <= PH_A;
			wr_s1       <= 1'b0;
			from_mem_s1 <= 1'b0;
			term_s1     <= atstk_pkg::T_XX;
			res_valid_q <= 1'b0;
			cur_q[atstk_pkg::T_XX] <= atstk_pkg::COEF_ONE;
			cur_q[atstk_pkg::T_XY] <= '0;
			cur_q[atstk_pkg::T_YX] <= '0;
			cur_q[atstk_pkg::T_YY] <= atstk_pkg::COEF_ONE;
			cur_q[atstk_pkg::T_WX] <= '0;
			cur_q[atstk_pkg::T_WY] <= '0;
		end else begin
			wr_s1 <= 1'b0;

			if (finish_go) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						op_q     <= item.operation;
						status_q <= atstk_pkg::STATUS_OK;
						term_q   <= atstk_pkg::T_XX;
						phase_q  <= PH_A;
						case (item.operation)
							atstk_pkg::OP_COMPOSE, atstk_pkg::OP_TRANSLATE,
							atstk_pkg::OP_POINT, atstk_pkg::OP_VECTOR: begin
								state_q <= ST_MAC;
							end
							atstk_pkg::OP_SAVE: begin
								if (count_q >= CNT_FULL) begin
									status_q <= atstk_pkg::STATUS_FULL;
									state_q  <= ST_FINISH;
								end else begin
									state_q <= ST_SAVE;
								end
							end
							atstk_pkg::OP_RESTORE: begin
								if (count_q == '0) begin
									status_q <= atstk_pkg::STATUS_BOTTOM;
									state_q  <= ST_FINISH;
								end else begin
									state_q <= ST_LOAD;
								end
							end
							atstk_pkg::OP_DIRECTION: begin
								if (dir_ok) begin
									state_q <= ST_MAC;
								end else begin
									status_q <= atstk_pkg::STATUS_BADDIR;
									state_q  <= ST_FINISH;
								end
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_MAC: begin
					if (last_phase) begin
						wr_s1       <= 1'b1;
						from_mem_s1 <= 1'b0;
						term_s1     <= term_q;
						phase_q     <= PH_A;
						if (last_term) begin
							state_q <= ST_FINISH;
						end else begin
							term_q <= term_q + atstk_pkg::TERM_W'(1);
						end
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				ST_SAVE: begin
					if (term_q == atstk_pkg::T_WY) begin
						state_q <= ST_FINISH;
					end else begin
						term_q <= term_q + atstk_pkg::TERM_W'(1);
					end
				end
				ST_LOAD: begin
					// Read data shows up in the next cycle and lands in new_q then.
					wr_s1       <= 1'b1;
					from_mem_s1 <= 1'b1;
					term_s1     <= term_q;
					if (term_q == atstk_pkg::T_WY) begin
						state_q <= ST_FINISH;
					end else begin
						term_q <= term_q + atstk_pkg::TERM_W'(1);
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
						case (op_q)
							atstk_pkg::OP_COMPOSE, atstk_pkg::OP_TRANSLATE: begin
								cur_q <= new_q;
							end
							atstk_pkg::OP_SAVE: begin
								if (status_q == atstk_pkg::STATUS_OK) begin
									count_q <= count_q + atstk_pkg::CNT_W'(1);
								end
							end
							atstk_pkg::OP_RESTORE: begin
								if (status_q == atstk_pkg::STATUS_OK) begin
									count_q <= count_q - atstk_pkg::CNT_W'(1);
									cur_q   <= new_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item_valid) begin
			case (item.operation)
				atstk_pkg::OP_COMPOSE: begin
					b_q[atstk_pkg::T_XX] <= atstk_pkg::to_coef(item.m_xx);
					b_q[atstk_pkg::T_XY] <= atstk_pkg::to_coef(item.m_xy);
					b_q[atstk_pkg::T_YX] <= atstk_pkg::to_coef(item.m_yx);
					b_q[atstk_pkg::T_YY] <= atstk_pkg::to_coef(item.m_yy);
					b_q[atstk_pkg::T_WX] <= atstk_pkg::to_coef(item.m_wx);
					b_q[atstk_pkg::T_WY] <= atstk_pkg::to_coef(item.m_wy);
				end
				atstk_pkg::OP_TRANSLATE: begin
					b_q[atstk_pkg::T_XX] <= atstk_pkg::COEF_ONE;
					b_q[atstk_pkg::T_XY] <= '0;
					b_q[atstk_pkg::T_YX] <= '0;
					b_q[atstk_pkg::T_YY] <= atstk_pkg::COEF_ONE;
					b_q[atstk_pkg::T_WX] <= atstk_pkg::to_coef(item.point_x);
					b_q[atstk_pkg::T_WY] <= atstk_pkg::to_coef(item.point_y);
				end
				atstk_pkg::OP_POINT, atstk_pkg::OP_VECTOR: begin
					b_q[atstk_pkg::T_XX] <= atstk_pkg::to_coef(item.point_x);
					b_q[atstk_pkg::T_XY] <= atstk_pkg::to_coef(item.point_y);
				end
				atstk_pkg::OP_DIRECTION: begin
					b_q[atstk_pkg::T_XX] <= dir_x;
					b_q[atstk_pkg::T_XY] <= dir_y;
				end
				default: begin
				end
			endcase
		end

		if (wr_s1) begin
			new_q[term_s1] <= from_mem_s1 ? ram_rdata : acc;
		end

		if (finish_go) begin
			res_q.out_x  <= (is_apply && (status_q == atstk_pkg::STATUS_OK)) ?
			                atstk_pkg::to_out(new_q[atstk_pkg::T_XX]) : '0;
			res_q.out_y  <= (is_apply && (status_q == atstk_pkg::STATUS_OK)) ?
			                atstk_pkg::to_out(new_q[atstk_pkg::T_XY]) : '0;
			res_q.status <= status_q;
		end
	end

	`AT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`AT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready)
	`AT_ASSERT_IMP(a_save_has_room, clk, arst_n, ram_we, count_q < CNT_FULL)
	`AT_ASSERT_IMP(a_restore_not_empty, clk, arst_n, (state_q == ST_FINISH) && (op_q == atstk_pkg::OP_RESTORE) && (status_q == atstk_pkg::STATUS_OK), count_q != '0)
	`AT_ASSERT_IMP(a_term_write_state, clk, arst_n, wr_s1, (state_q == ST_MAC) || (state_q == ST_LOAD) || (state_q == ST_FINISH))

endmodule
